FILE: rtl/pf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf_pkg: shared types and constants for the Playfair digraph cipher
// Letter coding, operation codes and the select bundle used between the
// pair mapper and the top level.
// ----------------------------------------------------------------------------
package pf_pkg;

   typedef logic [4:0] letter_type;
   typedef logic [1:0] op_type;

   localparam int SIDE  = 5;
   localparam int CELLS = SIDE * SIDE;

   localparam logic [4:0] CELL_COUNT = 5'(CELLS);

   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_Z = 5'd25;

   localparam op_type OP_START    = 2'd0;
   localparam op_type OP_KEY      = 2'd1;
   localparam op_type OP_COMPLETE = 2'd2;
   localparam op_type OP_ENCRYPT  = 2'd3;

   // one-hot cell selects for the two cipher letters
   typedef struct packed {
      logic [CELLS-1:0] first;
      logic [CELLS-1:0] second;
   } sel_pair_type;

   // saturate to Z, then fold J onto I
   function automatic letter_type norm_letter(input letter_type v);
      letter_type c;
      c = (v > LETTER_Z) ? LETTER_Z : v;
      return (c == LETTER_J) ? LETTER_I : c;
   endfunction

endpackage

FILE: rtl/pf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf_cell: one cell of the key square chain
// Holds one letter, passes it to its lower neighbor on a shift, compares it
// against the two probe letters and gates it onto the read-out bus.
// ----------------------------------------------------------------------------
module pf_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  pf_pkg::letter_type shift_letter,
   input  pf_pkg::letter_type probe_first,
   input  pf_pkg::letter_type probe_second,
   input  logic               pick_first,
   input  logic               pick_second,
   output pf_pkg::letter_type letter,
   output logic               hit_first,
   output logic               hit_second,
   output pf_pkg::letter_type out_first,
   output pf_pkg::letter_type out_second
);
   import pf_pkg::*;

   letter_type letter_ff;
   letter_type letter_in;

   assign letter_in = shift_en ? shift_letter : letter_ff;

   always_ff @(posedge clock) begin
      letter_ff <= letter_in;
   end

   assign letter     = letter_ff;
   assign hit_first  = (letter_ff == probe_first);
   assign hit_second = (letter_ff == probe_second);
   assign out_first  = letter_ff & {$bits(letter_type){pick_first}};
   assign out_second = letter_ff & {$bits(letter_type){pick_second}};

endmodule

FILE: rtl/pf_pair_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf_pair_map: Playfair position rules on one-hot cell positions
// Turns the match vectors of the two letters into row and column one-hots,
// applies the same-row, same-column and rectangle rules and returns the
// one-hot cells of the two cipher letters.
// ----------------------------------------------------------------------------
module pf_pair_map (
   input  logic [pf_pkg::CELLS-1:0] hit_first,
   input  logic [pf_pkg::CELLS-1:0] hit_second,
   output pf_pkg::sel_pair_type     sel
);
   import pf_pkg::*;

   logic [SIDE-1:0] row1, col1, row2, col2;
   logic [SIDE-1:0] orow1, ocol1, orow2, ocol2;

   always_comb begin
      row1 = '0;
      col1 = '0;
      row2 = '0;
      col2 = '0;
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            row1[r] = row1[r] | hit_first[r*SIDE + c];
            col1[c] = col1[c] | hit_first[r*SIDE + c];
            row2[r] = row2[r] | hit_second[r*SIDE + c];
            col2[c] = col2[c] | hit_second[r*SIDE + c];
         end
      end
   end

   // a rotate of a one-hot by one place steps right or down, wrapping
   always_comb begin
      if (row1 == row2) begin
         orow1 = row1;
         orow2 = row2;
         ocol1 = {col1[SIDE-2:0], col1[SIDE-1]};
         ocol2 = {col2[SIDE-2:0], col2[SIDE-1]};
      end else if (col1 == col2) begin
         orow1 = {row1[SIDE-2:0], row1[SIDE-1]};
         orow2 = {row2[SIDE-2:0], row2[SIDE-1]};
         ocol1 = col1;
         ocol2 = col2;
      end else begin
         orow1 = row1;
         orow2 = row2;
         ocol1 = col2;
         ocol2 = col1;
      end
   end

   always_comb begin
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            sel.first[r*SIDE + c]  = orow1[r] & ocol1[c];
            sel.second[r*SIDE + c] = orow2[r] & ocol2[c];
         end
      end
   end

endmodule

FILE: rtl/playfair_digraph_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_top: Playfair encryption with a 5x5 key square
// Key square held in a chain of 25 letter cells; encrypts letter pairs.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: req_tuser = operation (start, key letter, complete,
//   encrypt); req_tdata carries key_letter and the plaintext pair.
//   rsp_ channel: one transfer per encrypt, cipher pair in rsp_tdata and
//   the not_ready flag in rsp_tuser. Other operations return nothing.
//   Key letters enter at the tail of the cell chain and shift toward cell 0,
//   so after 25 letters cell n holds the n-th letter of the square.
// Operation steps:
//   start and key letter are done in the accept cycle.
//   complete: after the accept, the fill counter walks the alphabet A..Z,
//   pushing unused letters into the chain.
//   encrypt: accept, cell compare and position map, then read-out into the
//   output register, which raises rsp_tvalid.
// Reset clears the used-letter mask, fill count and complete flag; the square
// must be rebuilt. A stalled rsp_ side holds the result; the block still takes
// new operations, and an encrypt waits in its read-out state, with req_tready
// low, until the output register is free.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // key_letter[4:0], plain_first[9:5], plain_second[14:10]
   input  logic [1:0]  req_tuser,  // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // cipher_first[4:0], cipher_second[9:5]
   output logic        rsp_tuser   // not_ready
);
   import pf_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FILL  = 2'd1;
   localparam logic [1:0] S_MATCH = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [25:0]      used_ff, used_in;
   logic [4:0]       filled_ff, filled_in;
   logic             complete_ff, complete_in;
   letter_type       fill_k_ff, fill_k_in;
   letter_type       probe_first_ff, probe_first_in;
   letter_type       probe_second_ff, probe_second_in;
   logic             pend_nr_ff, pend_nr_in;
   sel_pair_type     sel_ff, sel_in;
   logic             rsp_valid_ff, rsp_valid_in;
   letter_type       rsp_first_ff, rsp_first_in;
   letter_type       rsp_second_ff, rsp_second_in;
   logic             rsp_nr_ff, rsp_nr_in;

   logic             accept;
   op_type           op;
   letter_type       key;
   logic [31:0]      used_ext;
   logic             shift_en;
   letter_type       shift_letter;
   logic             room;

   letter_type       cell_letter [CELLS];
   letter_type       cell_out1 [CELLS];
   letter_type       cell_out2 [CELLS];
   logic [CELLS-1:0] hit_first, hit_second;
   letter_type       pick_first, pick_second;
   sel_pair_type     map_sel;

   assign accept   = req_tvalid && req_tready;
   assign op       = req_tuser;
   assign key      = req_tdata[4:0];
   assign used_ext = {6'b0, used_ff};
   assign room     = (filled_ff < CELL_COUNT);

   // ---- cell chain ----
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      letter_type next_letter;
      if (i == CELLS - 1) begin : g_tail
         assign next_letter = shift_letter;
      end else begin : g_mid
         assign next_letter = cell_letter[i+1];
      end
      pf_cell u_cell (
         .clock        (clock),
         .shift_en     (shift_en),
         .shift_letter (next_letter),
         .probe_first  (probe_first_ff),
         .probe_second (probe_second_ff),
         .pick_first   (sel_ff.first[i]),
         .pick_second  (sel_ff.second[i]),
         .letter       (cell_letter[i]),
         .hit_first    (hit_first[i]),
         .hit_second   (hit_second[i]),
         .out_first    (cell_out1[i]),
         .out_second   (cell_out2[i])
      );
   end

   pf_pair_map u_map (
      .hit_first  (hit_first),
      .hit_second (hit_second),
      .sel        (map_sel)
   );

   always_comb begin
      pick_first  = '0;
      pick_second = '0;
      for (int i = 0; i < CELLS; i++) begin
         pick_first  = pick_first  | cell_out1[i];
         pick_second = pick_second | cell_out2[i];
      end
   end

   // ---- control ----
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      used_in         = used_ff;
      filled_in       = filled_ff;
      complete_in     = complete_ff;
      fill_k_in       = fill_k_ff;
      probe_first_in  = probe_first_ff;
      probe_second_in = probe_second_ff;
      pend_nr_in      = pend_nr_ff;
      sel_in          = sel_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_first_in    = rsp_first_ff;
      rsp_second_in   = rsp_second_ff;
      rsp_nr_in       = rsp_nr_ff;
      shift_en        = 1'b0;
      shift_letter    = key;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_START: begin
                     used_in     = '0;
                     filled_in   = '0;
                     complete_in = 1'b0;
                  end
                  OP_KEY: begin
                     if (!complete_ff && key <= LETTER_Z && key != LETTER_J &&
                         !used_ext[key] && room) begin
                        shift_en     = 1'b1;
                        shift_letter = key;
                        used_in      = used_ff | (26'd1 << key);
                        filled_in    = filled_ff + 5'd1;
                     end
                  end
                  OP_COMPLETE: begin
                     if (!complete_ff) begin
                        fill_k_in = '0;
                        state_in  = S_FILL;
                     end
                  end
                  OP_ENCRYPT: begin
                     probe_first_in  = norm_letter(req_tdata[9:5]);
                     probe_second_in = norm_letter(req_tdata[14:10]);
                     pend_nr_in      = !complete_ff;
                     state_in        = S_MATCH;
                  end
                  default: ;
               endcase
            end
         end
         S_FILL: begin
            if (fill_k_ff != LETTER_J && !used_ext[fill_k_ff] && room) begin
               shift_en     = 1'b1;
               shift_letter = fill_k_ff;
               used_in      = used_ff | (26'd1 << fill_k_ff);
               filled_in    = filled_ff + 5'd1;
            end
            if (fill_k_ff == LETTER_Z) begin
               complete_in = 1'b1;
               state_in    = S_IDLE;
            end else begin
               fill_k_in = fill_k_ff + 5'd1;
            end
         end
         S_MATCH: begin
            sel_in   = map_sel;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = pend_nr_ff ? '0 : pick_first;
               rsp_second_in = pend_nr_ff ? '0 : pick_second;
               rsp_nr_in     = pend_nr_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         filled_ff    <= '0;
         complete_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         filled_ff    <= filled_in;
         complete_ff  <= complete_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_k_ff       <= fill_k_in;
      probe_first_ff  <= probe_first_in;
      probe_second_ff <= probe_second_in;
      pend_nr_ff      <= pend_nr_in;
      sel_ff          <= sel_in;
      rsp_first_ff    <= rsp_first_in;
      rsp_second_ff   <= rsp_second_in;
      rsp_nr_ff       <= rsp_nr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_second_ff, rsp_first_ff};
   assign rsp_tuser  = rsp_nr_ff;

   // ---- assertions ----
   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(filled_ff) && !used_ff[LETTER_J])
      else $error("used-letter mask out of step with fill count");

   a_complete_full: assert property (@(posedge clock) disable iff (reset)
      complete_ff |-> filled_ff == CELL_COUNT)
      else $error("square marked complete without 25 letters");

   a_fill_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL && fill_k_ff == LETTER_Z) |=> complete_ff && filled_ff == CELL_COUNT)
      else $error("fill pass ended without a full square");

   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !pend_nr_ff) |-> $onehot(sel_ff.first) && $onehot(sel_ff.second))
      else $error("cipher cell select not one-hot");

endmodule

FILE: tb/sv/playfair_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_checker: cipher pair predictor and result comparator
// Watches the req_ and rsp_ channels of the Playfair block. It keeps its own
// copy of the key square, used-letter mask and fill count, predicts the
// result of every accepted encrypt, and compares each rsp_ transfer field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module playfair_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          mismatch_count,
   output int          pending_count
);
   import pf_pkg::*;

   typedef struct {
      letter_type first;
      letter_type second;
      logic       not_ready;
   } cipher_pair_type;

   letter_type      square [CELLS];
   logic [25:0]     used_mask;
   int              fill_count;
   bit              square_done;
   cipher_pair_type cipher_expected[$];
   cipher_pair_type want;
   int              errors;

   initial begin
      errors = 0;
   end

   function automatic letter_type fold_letter(input letter_type v);
      letter_type c;
      c = (v > LETTER_Z) ? LETTER_Z : v;
      if (c == LETTER_J) c = LETTER_I;
      return c;
   endfunction

   function automatic int cell_index(input letter_type l);
      for (int i = 0; i < CELLS; i++)
         if (square[i] == l) return i;
      return 0;
   endfunction

   function automatic void place_letter(input letter_type l);
      if (fill_count < CELLS) begin
         square[fill_count] = l;
         fill_count++;
         used_mask[l] = 1'b1;
      end
   endfunction

   function automatic cipher_pair_type encipher(input letter_type a, input letter_type b);
      cipher_pair_type r;
      int pa, pb, ra, ca, rb, cb, oa, ob;
      r.first     = '0;
      r.second    = '0;
      r.not_ready = 1'b1;
      if (!square_done) return r;
      pa = cell_index(fold_letter(a));
      pb = cell_index(fold_letter(b));
      ra = pa / SIDE;  ca = pa % SIDE;
      rb = pb / SIDE;  cb = pb % SIDE;
      if (ra == rb) begin
         oa = ra * SIDE + (ca + 1) % SIDE;
         ob = rb * SIDE + (cb + 1) % SIDE;
      end else if (ca == cb) begin
         oa = ((ra + 1) % SIDE) * SIDE + ca;
         ob = ((rb + 1) % SIDE) * SIDE + cb;
      end else begin
         // rectangle: swap columns
         oa = ra * SIDE + cb;
         ob = rb * SIDE + ca;
      end
      r.first     = square[oa];
      r.second    = square[ob];
      r.not_ready = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         used_mask   = '0;
         fill_count  = 0;
         square_done = 1'b0;
         cipher_expected.delete();
      end else begin
         // check before predicting: a result never belongs to a same-edge request
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_expected.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: rsp transfer with nothing expected: data=%h flag=%b",
                           $realtime, rsp_tdata, rsp_tuser);
            end else begin
               want = cipher_expected.pop_front();
               if (rsp_tdata[4:0] !== want.first || rsp_tdata[9:5] !== want.second ||
                   rsp_tuser !== want.not_ready) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t: cipher mismatch: expected first=%0d second=%0d ",
                               "not_ready=%b, got first=%0d second=%0d not_ready=%b"},
                              $realtime, want.first, want.second, want.not_ready,
                              rsp_tdata[4:0], rsp_tdata[9:5], rsp_tuser);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            case (op_type'(req_tuser))
               OP_START: begin
                  used_mask   = '0;
                  fill_count  = 0;
                  square_done = 1'b0;
               end
               OP_KEY: begin
                  if (!square_done && req_tdata[4:0] <= LETTER_Z &&
                      req_tdata[4:0] != LETTER_J && !used_mask[req_tdata[4:0]])
                     place_letter(req_tdata[4:0]);
               end
               OP_COMPLETE: begin
                  if (!square_done) begin
                     for (int k = 0; k <= LETTER_Z; k++)
                        if (k != LETTER_J && !used_mask[k]) place_letter(5'(k));
                     square_done = 1'b1;
                  end
               end
               default: begin
                  cipher_expected.push_back(encipher(req_tdata[9:5], req_tdata[14:10]));
               end
            endcase
         end
      end
      pending_count  <= cipher_expected.size();
      mismatch_count <= errors;
   end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the Playfair digraph cipher
// Builds key squares from random keys (with ignored letters mixed in), then
// encrypts random pairs, under random gaps and back-pressure. Directed items
// cover the edge cases first; the checker does all prediction and compare.
// ----------------------------------------------------------------------------
module tb;
   import pf_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // key_letter[4:0], plain_first[9:5], plain_second[14:10]
   logic [1:0]  req_tuser;   // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // cipher_first[4:0], cipher_second[9:5]
   logic        rsp_tuser;   // not_ready

   int mismatch_count;
   int pending_count;
   int sent_items;
   int stall_left;
   bit no_idle;
   int hold_requests;
   int holds_served;

   playfair_digraph_cipher_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   playfair_checker check_u (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(4_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stall after each transfer, long hold-off on request
   initial begin
      rsp_tready   = 1'b0;
      stall_left   = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_tvalid && rsp_tready)
               stall_left = no_idle ? 0 : $urandom_range(0, 11);
            if (hold_requests != holds_served) begin
               stall_left   = 300;
               holds_served = hold_requests;
            end
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   function automatic letter_type rand_letter();
      if ($urandom_range(0, 9) == 0) return 5'($urandom_range(26, 31));
      return 5'($urandom_range(0, 25));
   endfunction

   function automatic letter_type any5();
      return 5'($urandom_range(0, 31));
   endfunction

   // valid is left high after the transfer; the next call or wait_idle settles it
   task automatic send_item(input op_type op, input letter_type k,
                            input letter_type a, input letter_type b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, b, a, k};
      do @(posedge clock); while (!req_tready);
      if (!(op == OP_KEY && (k > LETTER_Z || k == LETTER_J))) sent_items++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic encrypt_random();
      letter_type a;
      a = rand_letter();
      if ($urandom_range(0, 9) == 0) send_item(OP_ENCRYPT, any5(), a, a);
      else send_item(OP_ENCRYPT, any5(), a, rand_letter());
   endtask

   task automatic run_session(input bit squeeze);
      int nkeys, nenc;
      no_idle = ($urandom_range(0, 4) == 0);
      if (!squeeze && $urandom_range(0, 6) == 0) begin
         // noise: arbitrary operations
         repeat ($urandom_range(1, 10))
            send_item(op_type'($urandom_range(0, 3)), any5(), any5(), any5());
         return;
      end
      send_item(OP_START, any5(), any5(), any5());
      if ($urandom_range(0, 9) == 0) encrypt_random();
      nkeys = $urandom_range(0, 28);
      repeat (nkeys) send_item(OP_KEY, rand_letter(), any5(), any5());
      if ($urandom_range(0, 19) != 0) send_item(OP_COMPLETE, any5(), any5(), any5());
      if (squeeze) begin
         no_idle = 1'b1;
         hold_requests++;
         nenc    = 40;
      end else begin
         nenc = $urandom_range(5, 30);
      end
      repeat (nenc) begin
         case ($urandom_range(0, 19))
            0:       send_item(OP_KEY, rand_letter(), any5(), any5());
            1:       send_item(OP_COMPLETE, any5(), any5(), any5());
            default: encrypt_random();
         endcase
      end
      if (squeeze || $urandom_range(0, 3) == 0) wait_idle();
   endtask

   initial begin
      int session;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = OP_START;
      no_idle       = 1'b0;
      hold_requests = 0;
      sent_items    = 0;
      session       = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // encrypt on an empty square, then a key with ignored letters
      send_item(OP_ENCRYPT, 5'd0, 5'd0, LETTER_Z);
      send_item(OP_KEY, 5'd31, 5'd31, 5'd31);
      send_item(OP_KEY, LETTER_J, 5'd0, 5'd0);
      send_item(OP_KEY, 5'd15, 5'd0, 5'd0);
      send_item(OP_KEY, 5'd11, 5'd0, 5'd0);
      send_item(OP_KEY, 5'd15, 5'd0, 5'd0);
      send_item(OP_KEY, LETTER_Z, 5'd0, 5'd0);
      send_item(OP_KEY, 5'd0, 5'd0, 5'd0);
      send_item(OP_ENCRYPT, 5'd0, 5'd1, 5'd2);
      send_item(OP_COMPLETE, 5'd0, 5'd0, 5'd0);
      send_item(OP_COMPLETE, 5'd31, 5'd31, 5'd31);
      send_item(OP_KEY, 5'd3, 5'd0, 5'd0);
      send_item(OP_ENCRYPT, 5'd31, 5'd0, LETTER_Z);
      // alphabetical square: row, column, rectangle, J folding, saturation, repeat
      send_item(OP_START, 5'd0, 5'd0, 5'd0);
      send_item(OP_COMPLETE, 5'd0, 5'd0, 5'd0);
      send_item(OP_ENCRYPT, 5'd0, 5'd0, 5'd4);
      send_item(OP_ENCRYPT, 5'd0, 5'd0, 5'd21);
      send_item(OP_ENCRYPT, 5'd0, 5'd1, 5'd7);
      send_item(OP_ENCRYPT, 5'd0, LETTER_J, LETTER_I);
      send_item(OP_ENCRYPT, 5'd0, 5'd31, 5'd26);
      send_item(OP_ENCRYPT, 5'd0, LETTER_Z, LETTER_Z);
      // a full key: every letter, J skipped
      send_item(OP_START, 5'd0, 5'd0, 5'd0);
      for (int k = LETTER_Z; k >= 0; k--) send_item(OP_KEY, 5'(k), any5(), any5());
      send_item(OP_KEY, 5'd4, 5'd0, 5'd0);
      send_item(OP_COMPLETE, 5'd0, 5'd0, 5'd0);
      send_item(OP_ENCRYPT, 5'd0, 5'd16, 5'd3);
      wait_idle();

      while (sent_items < 1100) begin
         run_session(session == 6);
         session++;
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/pf_pkg.sv
rtl/pf_cell.sv
rtl/pf_pair_map.sv
rtl/playfair_digraph_cipher_top.sv
tb/sv/playfair_checker.sv
tb/sv/tb.sv
